>>> rtl/core/rce_pkg.sv
// Package for the raised-cosine excitation block.
// Shared widths, codes and the controller/datapath command and status types.
// No dependencies.
package rce_pkg;

  localparam int unsigned GridPointsDef = 64;
  localparam int unsigned CosDepthDef   = 256;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned DecW     = 24;
  localparam int unsigned GridW    = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_POINTS    = 3'd0,
    CFG_WIDTH_SCALE    = 3'd1,
    CFG_DURATION_SCALE = 3'd2,
    CFG_FORCE_SCALE    = 3'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    OUT_NONE  = 2'd0,
    OUT_ACK   = 2'd1,
    OUT_IDLE  = 2'd2,
    OUT_POINT = 2'd3
  } out_kind_e;

  typedef enum logic {
    DIV_AMP   = 1'b0,
    DIV_POINT = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic      load_in;
    logic      st1;
    logic      st2;
    logic      commit;
    logic      clear_exc;
    logic      div_start;
    div_sel_e  div_sel;
    logic      look;
    logic      first_point;
    logic      amp;
    logic      next_point;
    logic      count_down;
    out_kind_e out_kind;
  } rce_cmd_t;

  typedef struct packed {
    logic tick_live;
    logic div_done;
    logic point_last;
  } rce_sts_t;

endpackage

>>> rtl/core/rce_if.sv
// Valid/ready channel interfaces for the excitation block's input and result items.
// Depends on rce_pkg for field widths.
interface rce_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [rce_pkg::FieldW-1:0]   strike_position;
  logic [rce_pkg::FieldW-1:0]   strike_force;
  logic [rce_pkg::FieldW-1:0]   strike_velocity;

  modport source (output valid, req_type, strike_position, strike_force, strike_velocity,
                  input ready);
  modport sink   (input valid, req_type, strike_position, strike_force, strike_velocity,
                  output ready);
endinterface

interface rce_out_if;
  logic                         valid;
  logic                         ready;
  logic [rce_pkg::IndexW-1:0]   grid_index;
  logic [rce_pkg::DecW-1:0]     displacement_decrement;
  logic                         active;
  logic                         last;

  modport source (output valid, grid_index, displacement_decrement, active, last,
                  input ready);
  modport sink   (input valid, grid_index, displacement_decrement, active, last,
                  output ready);
endinterface

>>> rtl/core/rce_div.sv
// Restoring divider giving the rounded table index round(num*Depth/den).
// One quotient bit per cycle. Depends on rce_pkg.
module rce_div #(
  parameter int unsigned CosDepth = rce_pkg::CosDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rce_pkg::FieldW-1:0]          num_i,
  input  logic [rce_pkg::FieldW-1:0]          den_i,
  output logic                                done_o,
  output logic [$clog2(CosDepth):0]           quo_o
);
  import rce_pkg::*;

  localparam int unsigned QW = $clog2(CosDepth) + 1;
  localparam int unsigned XW = QW + 18;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [XW-1:0] x_q, dv_q;
  logic [QW-1:0] q_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic          ge;

  // numerator 2*num*Depth + den, divisor 2*den aligned to the top quotient bit
  assign ge = (x_q >= dv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q  <= XW'(num_i) * XW'(2 * CosDepth) + XW'(den_i);
      dv_q <= XW'(den_i) << QW;
      q_q  <= '0;
    end else if (busy_q) begin
      if (ge) begin
        x_q <= x_q - dv_q;
      end
      q_q  <= {q_q[QW-2:0], ge};
      dv_q <= dv_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

>>> rtl/core/rce_dp.sv
// Datapath: configuration registers, strike state, raised-cosine table,
// multipliers and result register. Depends on rce_pkg and rce_div.
module rce_dp #(
  parameter int unsigned GridPoints = rce_pkg::GridPointsDef,
  parameter int unsigned CosDepth   = rce_pkg::CosDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rce_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rce_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [rce_pkg::FieldW-1:0]    strike_position_i,
  input  logic [rce_pkg::FieldW-1:0]    strike_force_i,
  input  logic [rce_pkg::FieldW-1:0]    strike_velocity_i,
  input  rce_pkg::rce_cmd_t             cmd_i,
  output rce_pkg::rce_sts_t             sts_o,
  output logic [rce_pkg::IndexW-1:0]    grid_index_o,
  output logic [rce_pkg::DecW-1:0]      displacement_decrement_o,
  output logic                          active_o,
  output logic                          last_o
);
  import rce_pkg::*;

  localparam int unsigned AW = $clog2(CosDepth);
  localparam int unsigned QW = AW + 1;
  localparam logic [63:0] Q30One    = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef logic [17:0] rom_t [CosDepth];

  // quotient by shift and subtract; used only while building the table
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos (odd=0) or sin (odd=1) in Q30 by Taylor series, a in [0, pi/2]
  function automatic logic [63:0] series(input logic [63:0] a, input logic odd);
    logic [63:0]        a2, term, n, dv;
    logic signed [63:0] acc;
    a2   = (a * a) >> 30;
    term = odd ? a : Q30One;
    n    = odd ? 64'd1 : 64'd0;
    acc  = signed'(term);
    for (int s = 0; s < 8; s++) begin
      term = (term * a2) >> 30;
      dv   = (n + 64'd1) * (n + 64'd2);
      term = udiv(term, dv);
      n    = n + 64'd2;
      if (s % 2 == 1) acc = acc + signed'(term);
      else            acc = acc - signed'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > signed'(Q30One)) acc = signed'(Q30One);
    return unsigned'(acc);
  endfunction

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] p, a, h, e;
    logic [1:0]  quad;
    for (int i = 0; i < CosDepth; i++) begin
      p    = (64'(i) << 32) >> AW;
      quad = p[31:30];
      a    = ((p & 64'h3FFF_FFFF) * HalfPiQ30) >> 30;
      case (quad)
        2'd0:    h = Q30One - series(a, 1'b0);
        2'd1:    h = Q30One + series(a, 1'b1);
        2'd2:    h = Q30One + series(a, 1'b0);
        default: h = Q30One - series(a, 1'b1);
      endcase
      e    = (h + 64'd8192) >> 14;
      r[i] = e[17:0];
    end
    return r;
  endfunction

  localparam rom_t RaisedRom = build_rom();

  // configuration
  logic [GridW-1:0]  cfg_n_q;
  logic [FieldW-1:0] cfg_ws_q, cfg_ds_q, cfg_fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_n_q  <= GridW'(64);
      cfg_ws_q <= 16'd16384;
      cfg_ds_q <= 16'd256;
      cfg_fs_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_POINTS:    cfg_n_q  <= cfg_data_i[GridW-1:0];
        CFG_WIDTH_SCALE:    cfg_ws_q <= cfg_data_i;
        CFG_DURATION_SCALE: cfg_ds_q <= cfg_data_i;
        CFG_FORCE_SCALE:    cfg_fs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // strike state
  logic [GridW-1:0]  span_width_q;
  logic [IndexW-1:0] span_start_q;
  logic [FieldW-1:0] total_q, left_q, held_force_q;
  logic              exciting_q;

  // working registers
  logic [FieldW-1:0] pos_q, force_q, vel_q;
  logic [22:0]       p1_q;
  logic [23:0]       t2_q;
  logic [31:0]       dprod_q;
  logic [GridW-1:0]  w_q;
  logic [FieldW-1:0] dur_q;
  logic [17:0]       t_q;
  logic [31:0]       m1_q;
  logic [28:0]       amp_q;
  logic [IndexW-1:0] l_q;

  logic [IndexW-1:0] out_idx_q;
  logic [DecW-1:0]   out_dec_q;
  logic              out_act_q, out_last_q;

  // grid size clamp
  logic [GridW-1:0] n_c, nm3, smax;
  always_comb begin
    if (cfg_n_q < GridW'(8))               n_c = GridW'(8);
    else if (cfg_n_q > GridW'(GridPoints)) n_c = GridW'(GridPoints);
    else                                   n_c = cfg_n_q;
    nm3  = n_c - GridW'(3);
    smax = n_c - w_q;
  end

  // width and duration
  logic [38:0]      wp;
  logic [GridW-1:0] w_c;
  logic [32:0]      dsum;
  logic [16:0]      draw;
  logic [FieldW-1:0] dur_c;
  always_comb begin
    wp   = 39'(p1_q) * 39'(force_q);
    if (wp[38:32] < GridW'(3)) w_c = GridW'(3);
    else if (wp[38:32] > nm3)  w_c = nm3;
    else                       w_c = wp[38:32];
    dsum = 33'(dprod_q) + 33'd32768;
    draw = dsum[32:16];
    if (draw < 17'd2)          dur_c = 16'd2;
    else if (draw[16])         dur_c = 16'hFFFF;
    else                       dur_c = draw[15:0];
  end

  // start index
  logic [23:0]      wide, sdiff;
  logic [GridW-1:0] sraw, s_c;
  always_comb begin
    wide  = {1'b0, w_q, 16'd0};
    sdiff = t2_q - wide;
    sraw  = (t2_q < wide) ? '0 : sdiff[23:17];
    if (sraw < GridW'(2))  s_c = GridW'(2);
    else if (sraw > smax)  s_c = smax;
    else                   s_c = sraw;
  end

  // divider and table lookup
  logic [FieldW-1:0] div_num, div_den;
  logic [QW-1:0]     quo;
  logic [AW-1:0]     rom_idx;
  logic              div_done;

  assign div_num = (cmd_i.div_sel == DIV_POINT) ? FieldW'(l_q) : left_q;
  assign div_den = (cmd_i.div_sel == DIV_POINT) ? FieldW'(span_width_q) : total_q;

  rce_div #(.CosDepth(CosDepth)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // index wraps once around the period
  assign rom_idx = (quo >= QW'(CosDepth)) ? '0 : quo[AW-1:0];

  logic [49:0] ampw;
  logic [46:0] decw;
  logic [DecW-1:0] dec_sat;
  assign ampw    = 50'(m1_q) * 50'(t_q);
  assign decw    = 47'(amp_q) * 47'(t_q);
  assign dec_sat = (|decw[46:40]) ? '1 : decw[39:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_width_q <= '0;
      span_start_q <= '0;
      total_q      <= '0;
      left_q       <= '0;
      held_force_q <= '0;
      exciting_q   <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        span_width_q <= w_q;
        span_start_q <= s_c[IndexW-1:0];
        total_q      <= dur_q;
        left_q       <= dur_q;
        held_force_q <= force_q;
        exciting_q   <= 1'b1;
      end
      if (cmd_i.clear_exc)  exciting_q <= 1'b0;
      if (cmd_i.count_down) left_q     <= left_q - 16'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pos_q   <= strike_position_i;
      force_q <= strike_force_i;
      vel_q   <= strike_velocity_i;
    end
    if (cmd_i.st1) begin
      p1_q    <= 23'(n_c) * 23'(cfg_ws_q);
      t2_q    <= (24'(n_c) * 24'(pos_q)) << 1;
      dprod_q <= 32'(vel_q) * 32'(cfg_ds_q);
    end
    if (cmd_i.st2) begin
      w_q   <= w_c;
      dur_q <= dur_c;
    end
    if (cmd_i.look) begin
      t_q  <= RaisedRom[rom_idx];
      m1_q <= 32'(held_force_q) * 32'(cfg_fs_q);
    end
    if (cmd_i.amp)         amp_q <= ampw[49:21];
    if (cmd_i.first_point) l_q   <= '0;
    if (cmd_i.next_point)  l_q   <= l_q + IndexW'(1);
    case (cmd_i.out_kind)
      OUT_ACK: begin
        out_idx_q  <= s_c[IndexW-1:0];
        out_dec_q  <= '0;
        out_act_q  <= 1'b1;
        out_last_q <= 1'b1;
      end
      OUT_IDLE: begin
        out_idx_q  <= '0;
        out_dec_q  <= '0;
        out_act_q  <= 1'b0;
        out_last_q <= 1'b1;
      end
      OUT_POINT: begin
        out_idx_q  <= span_start_q + l_q;
        out_dec_q  <= dec_sat;
        out_act_q  <= 1'b1;
        out_last_q <= sts_o.point_last;
      end
      default: ;
    endcase
  end

  assign sts_o.tick_live  = exciting_q && (left_q != '0) && (span_width_q != '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.point_last = ((GridW'(l_q) + GridW'(1)) == span_width_q);

  assign grid_index_o             = out_idx_q;
  assign displacement_decrement_o = out_dec_q;
  assign active_o                 = out_act_q;
  assign last_o                   = out_last_q;

endmodule

>>> rtl/core/rce_ctrl.sv
// Controller state machine: sequences start setup, tick amplitude and the
// per-point loop, and owns both handshakes. Depends on rce_pkg.
module rce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_req_type_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rce_pkg::rce_sts_t sts_i,
  output rce_pkg::rce_cmd_t cmd_o
);
  import rce_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ST1   = 12'b0000_0000_0010,
    S_ST2   = 12'b0000_0000_0100,
    S_ST3   = 12'b0000_0000_1000,
    S_KDIV  = 12'b0000_0001_0000,
    S_KLOOK = 12'b0000_0010_0000,
    S_AMP   = 12'b0000_0100_0000,
    S_PSET  = 12'b0000_1000_0000,
    S_PDIV  = 12'b0001_0000_0000,
    S_PLOOK = 12'b0010_0000_0000,
    S_PMUL  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   loop_q, loop_d;

  always_comb begin
    state_d     = state_q;
    loop_d      = loop_q;
    cmd_o       = '0;
    cmd_o.div_sel  = DIV_AMP;
    cmd_o.out_kind = OUT_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (in_req_type_i == REQ_START) begin
            state_d = S_ST1;
          end else if (sts_i.tick_live) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_KDIV;
          end else begin
            cmd_o.clear_exc = 1'b1;
            cmd_o.out_kind  = OUT_IDLE;
            loop_d          = 1'b0;
            state_d         = S_OUT;
          end
        end
      end
      S_ST1: begin
        cmd_o.st1 = 1'b1;
        state_d   = S_ST2;
      end
      S_ST2: begin
        cmd_o.st2 = 1'b1;
        state_d   = S_ST3;
      end
      S_ST3: begin
        cmd_o.commit   = 1'b1;
        cmd_o.out_kind = OUT_ACK;
        loop_d         = 1'b0;
        state_d        = S_OUT;
      end
      S_KDIV: begin
        if (sts_i.div_done) state_d = S_KLOOK;
      end
      S_KLOOK: begin
        cmd_o.look        = 1'b1;
        cmd_o.first_point = 1'b1;
        state_d           = S_AMP;
      end
      S_AMP: begin
        cmd_o.amp = 1'b1;
        state_d   = S_PSET;
      end
      S_PSET: begin
        cmd_o.div_sel   = DIV_POINT;
        cmd_o.div_start = 1'b1;
        state_d         = S_PDIV;
      end
      S_PDIV: begin
        cmd_o.div_sel = DIV_POINT;
        if (sts_i.div_done) state_d = S_PLOOK;
      end
      S_PLOOK: begin
        cmd_o.div_sel = DIV_POINT;
        cmd_o.look    = 1'b1;
        state_d       = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.out_kind = OUT_POINT;
        loop_d         = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (loop_q && !sts_i.point_last) begin
            cmd_o.next_point = 1'b1;
            state_d          = S_PSET;
          end else begin
            if (loop_q) cmd_o.count_down = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      loop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      loop_q  <= loop_d;
    end
  end

endmodule

>>> rtl/core/raised_cosine_excitation.sv
// Raised-cosine strike generator for a finite-difference string grid.
// One input channel (start/tick items), one result channel, a write-only
// configuration port. Depends on rce_pkg, rce_if, rce_ctrl, rce_dp, rce_div.
//
// Usage:
//  - A start item (req_type 0) latches position, force and velocity and
//    returns one acknowledgment item carrying the start index.
//  - A tick item (req_type 1) on a running strike returns W items, one per
//    grid point of the strike width, in grid order; last marks the final one.
//    Each tick first sets up the amplitude once; each point then takes a
//    pass of the bit-serial divider that forms the table index.
//  - A tick with nothing running returns one inactive item.
//  - One item is processed at a time; the input is not ready until the
//    final result of the previous item has been taken.
//  - A stalled result holds in the output register; the block waits.
//  - Reset loads the register defaults and leaves the block idle. The
//    cosine table is a constant and needs no fill time.
module raised_cosine_excitation #(
  parameter int unsigned GridPoints = rce_pkg::GridPointsDef,
  parameter int unsigned CosDepth   = rce_pkg::CosDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rce_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rce_pkg::CfgDataW-1:0]  cfg_data_i,
  rce_in_if.sink                        in_ch,
  rce_out_if.source                     out_ch
);
  import rce_pkg::*;

  rce_cmd_t cmd;
  rce_sts_t sts;

  rce_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_req_type_i (in_ch.req_type),
    .in_ready_o    (in_ch.ready),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  rce_dp #(.GridPoints(GridPoints), .CosDepth(CosDepth)) u_dp (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_idx_i                (cfg_idx_i),
    .cfg_data_i               (cfg_data_i),
    .strike_position_i        (in_ch.strike_position),
    .strike_force_i           (in_ch.strike_force),
    .strike_velocity_i        (in_ch.strike_velocity),
    .cmd_i                    (cmd),
    .sts_o                    (sts),
    .grid_index_o             (out_ch.grid_index),
    .displacement_decrement_o (out_ch.displacement_decrement),
    .active_o                 (out_ch.active),
    .last_o                   (out_ch.last)
  );

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  a_mid_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.last) |-> out_ch.active)
    else $error("non-final result of a tick must be active");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.active) |->
      (out_ch.grid_index == '0 && out_ch.displacement_decrement == '0))
    else $error("inactive result carries data");
`endif

endmodule

>>> dv/rce_checker.sv
// Scoreboard for the raised-cosine excitation block: watches both channels,
// predicts every result item and compares. Depends on rce_pkg and rce_if.
`timescale 1ns / 1ps
module rce_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  rce_in_if           in_ch,
  rce_out_if          out_ch,
  output int          fail_count_o,
  output int          pending_o
);
  import rce_pkg::*;

  localparam int unsigned Depth = CosDepthDef;

  typedef struct packed {
    logic [5:0]  idx;
    logic [23:0] dec;
    logic        act;
    logic        lst;
  } strike_res_t;

  strike_res_t expected_q[$];
  logic [31:0] half_cos_rom[Depth];

  logic [6:0]  m_grid;
  logic [15:0] m_wscale, m_dscale, m_fscale;
  logic [6:0]  m_width;
  logic [5:0]  m_start;
  logic [15:0] m_total, m_left, m_force;
  logic        m_running;

  function automatic logic [63:0] taylor_q30(logic [63:0] a, bit odd);
    logic [63:0] a2, term, n;
    longint acc;
    a2 = (a * a) >> 30;
    term = odd ? a : 64'd1073741824;
    n = odd ? 1 : 0;
    acc = longint'(term);
    for (int s = 0; s < 8; s++) begin
      term = (term * a2) >> 30;
      term = term / ((n + 1) * (n + 2));
      n += 2;
      if (s & 1) acc += longint'(term);
      else acc -= longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 1073741824) acc = 1073741824;
    return 64'(acc);
  endfunction

  function automatic logic [31:0] half_cos(logic [31:0] num, logic [31:0] den);
    logic [63:0] i;
    if (den == 0) return half_cos_rom[0];
    i = (64'(num) * 2 * Depth + den) / (2 * 64'(den));
    return half_cos_rom[i % Depth];
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  task automatic predict_item(logic rq, logic [15:0] pos, logic [15:0] frc,
                              logic [15:0] vel);
    logic [63:0] n, w, t2, wide, s, dur, amp, dec;
    if (rq == REQ_START) begin
      n = m_grid;
      if (n < 8) n = 8;
      if (n > GridPointsDef) n = GridPointsDef;
      w = (n * m_wscale * frc) >> 32;
      if (w < 3) w = 3;
      if (w > n - 3) w = n - 3;
      t2 = 2 * n * pos;
      wide = w << 16;
      s = (t2 < wide) ? 0 : ((t2 - wide) >> 17);
      if (s < 2) s = 2;
      if (s > n - w) s = n - w;
      dur = (64'(vel) * m_dscale + 32768) >> 16;
      if (dur < 2) dur = 2;
      if (dur > 65535) dur = 65535;
      m_width = w[6:0]; m_start = s[5:0]; m_total = dur[15:0]; m_left = dur[15:0];
      m_force = frc; m_running = 1'b1;
      expected_q.push_back('{s[5:0], 24'd0, 1'b1, 1'b1});
    end else if (m_running && m_left != 0 && m_width != 0) begin
      amp = (64'(m_force) * m_fscale * half_cos(m_left, m_total)) >> 21;
      for (int l = 0; l < m_width; l++) begin
        dec = (amp * half_cos(l, m_width)) >> 16;
        if (dec > 24'hFFFFFF) dec = 24'hFFFFFF;
        expected_q.push_back('{6'(m_start + l), dec[23:0], 1'b1, l + 1 == m_width});
      end
      m_left = m_left - 1;
    end else begin
      m_running = 1'b0;
      expected_q.push_back('{6'd0, 24'd0, 1'b0, 1'b1});
    end
  endtask

  initial begin
    logic [63:0] p, a, h;
    for (int i = 0; i < Depth; i++) begin
      p = (64'(i) << 32) / Depth;
      a = ((p & 64'h3FFFFFFF) * 64'd1686629713) >> 30;
      case (p[31:30])
        2'd0: h = 64'd1073741824 - taylor_q30(a, 0);
        2'd1: h = 64'd1073741824 + taylor_q30(a, 1);
        2'd2: h = 64'd1073741824 + taylor_q30(a, 0);
        default: h = 64'd1073741824 - taylor_q30(a, 1);
      endcase
      half_cos_rom[i] = (h + 8192) >> 14;
    end
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    strike_res_t got, want;
    if (!rst_ni) begin
      m_grid = 64; m_wscale = 16384; m_dscale = 256; m_fscale = 256;
      m_width = 0; m_start = 0; m_total = 0; m_left = 0; m_force = 0;
      m_running = 1'b0;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      // Blocking updates of the model: the RTL sees old values this edge anyway.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRID_POINTS:    m_grid = cfg_data_i[6:0];
          CFG_WIDTH_SCALE:    m_wscale = cfg_data_i;
          CFG_DURATION_SCALE: m_dscale = cfg_data_i;
          CFG_FORCE_SCALE:    m_fscale = cfg_data_i;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.grid_index, out_ch.displacement_decrement, out_ch.active,
                out_ch.last};
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", 64'(got), 0);
        end else begin
          want = expected_q.pop_front();
          if (got.idx != want.idx) report_mismatch("grid_index", got.idx, want.idx);
          if (got.dec != want.dec) report_mismatch("decrement", got.dec, want.dec);
          if (got.act != want.act) report_mismatch("active", got.act, want.act);
          if (got.lst != want.lst) report_mismatch("last", got.lst, want.lst);
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_item(in_ch.req_type, in_ch.strike_position, in_ch.strike_force,
                     in_ch.strike_velocity);
    end
  end
endmodule

>>> dv/tb_top.sv
// Testbench top for raised_cosine_excitation: clock, reset, stimulus and verdict.
// Depends on rce_pkg, rce_if, rce_checker and the block itself.
`timescale 1ns / 1ps
module tb_top;
  import rce_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          stim_done = 0;

  rce_in_if  in_ch ();
  rce_out_if out_ch ();

  raised_cosine_excitation i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  rce_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch(in_ch), .out_ch(out_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    in_ch.valid <= 0; in_ch.req_type <= 0; in_ch.strike_position <= 0;
    in_ch.strike_force <= 0; in_ch.strike_velocity <= 0;
    out_ch.ready <= 0;
  end

  initial forever #2 clk_i = ~clk_i;

  // Worst run: 61 points per tick, each with a result stall, is well under the limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall per item; ready stays high across a zero gap.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // valid stays high after acceptance; drain or a next call with a gap lowers it
  task automatic send_item(logic rq, logic [15:0] pos, logic [15:0] frc,
                           logic [15:0] vel, int gap);
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1; in_ch.req_type <= rq; in_ch.strike_position <= pos;
    in_ch.strike_force <= frc; in_ch.strike_velocity <= vel;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      // Mostly ticks with an occasional start; short velocities keep strikes brief.
      if ($urandom_range(0, 5) == 0)
        send_item(REQ_START, $urandom, $urandom, $urandom_range(0, 4) == 0 ?
                  $urandom : $urandom_range(0, 1500), gap);
      else
        send_item(REQ_TICK, $urandom, $urandom, $urandom, gap);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: idle tick, field extremes, restart, countdown to end.
    send_item(REQ_TICK, 0, 0, 0, 0);
    send_item(REQ_START, 16'h0000, 16'hFFFF, 16'h0000, 0);
    send_item(REQ_TICK, 16'hFFFF, 0, 16'hFFFF, 0);
    send_item(REQ_TICK, 0, 0, 0, 3);
    send_item(REQ_TICK, 0, 0, 0, 0);
    send_item(REQ_TICK, 0, 0, 0, 0);
    send_item(REQ_START, 16'hFFFF, 16'h0000, 16'hFFFF, 1);
    send_item(REQ_TICK, 0, 0, 0, 0);
    send_item(REQ_START, 16'h8000, 16'h8000, 16'h0300, 0);
    send_item(REQ_TICK, 0, 0, 0, 0);
    send_item(REQ_START, 16'h5555, 16'hAAAA, 16'h0180, 2);
    repeat (4) send_item(REQ_TICK, 0, 0, 0, 0);
    drain();
    random_items(80);
    drain();
    // Small grid, extreme scales, out-of-range grid size and a bad index.
    write_reg(CFG_GRID_POINTS, 7'd3);
    write_reg(CFG_WIDTH_SCALE, 16'hFFFF);
    write_reg(CFG_DURATION_SCALE, 16'h0000);
    write_reg(CFG_FORCE_SCALE, 16'hFFFF);
    write_reg(cfg_idx_e'(3'd5), 16'h1234);
    send_item(REQ_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    random_items(70);
    drain();
    write_reg(CFG_GRID_POINTS, 7'd127);
    write_reg(CFG_WIDTH_SCALE, 16'h0000);
    write_reg(CFG_DURATION_SCALE, 16'h0040);
    write_reg(CFG_FORCE_SCALE, 16'h0000);
    random_items(60);
    drain();
    write_reg(CFG_GRID_POINTS, 7'($urandom_range(8, 64)));
    write_reg(CFG_WIDTH_SCALE, $urandom);
    write_reg(CFG_DURATION_SCALE, $urandom_range(0, 2048));
    write_reg(CFG_FORCE_SCALE, $urandom);
    random_items(90);
    drain();
    stim_done = 1;
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
